[rtl/core/cpt_pkg.sv]
// Shared types, constants and saturation helper for the cascaded PID tracking block.
// Used by cpt_mul, cpt_div and cascaded_pid_tracking_axis.
package cpt_pkg;

    localparam int DATA_W  = 32;
    localparam int GAIN_W  = 16;
    localparam int DT_W    = 16;
    localparam int PROD_W  = DATA_W + GAIN_W;
    localparam int ACC_W   = 56;
    localparam int CFG_W   = 48;
    localparam int CIDX_W  = 3;
    localparam int NUM_GAIN_REGS = 6;
    localparam int GAIN_AXES     = 3;

    localparam logic [CIDX_W-1:0] REG_POS_P = 3'd0;
    localparam logic [CIDX_W-1:0] REG_POS_I = 3'd1;
    localparam logic [CIDX_W-1:0] REG_POS_D = 3'd2;
    localparam logic [CIDX_W-1:0] REG_VEL_P = 3'd3;
    localparam logic [CIDX_W-1:0] REG_VEL_I = 3'd4;
    localparam logic [CIDX_W-1:0] REG_VEL_D = 3'd5;

    localparam logic signed [ACC_W-1:0] GRAVITY_ACC = ACC_W'(642253 * 256);
    localparam logic [1:0] GRAVITY_AXIS = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INT_GO,
        ST_INT_WAIT,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_MUL_GO,
        ST_MUL_WAIT,
        ST_OUT
    } cpt_state_t;

    // Clamp a wide signed value into 32 bits
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[DATA_W-1:0];
        return r;
    endfunction

endpackage

[rtl/core/cpt_mul.sv]
// Bit-serial multiplier: unsigned 16-bit times signed 32-bit, one multiplier bit per cycle.
// Depends on cpt_pkg.
module cpt_mul (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  start_i,
    input  logic [cpt_pkg::GAIN_W-1:0]            a_i,
    input  logic signed [cpt_pkg::DATA_W-1:0]     b_i,
    output logic                                  done_o,
    output logic signed [cpt_pkg::PROD_W-1:0]     prod_o
);
    import cpt_pkg::*;

    logic                     busy_reg;
    logic                     done_reg;
    logic [3:0]               cnt_reg;
    logic [GAIN_W-1:0]        a_reg;
    logic signed [PROD_W-1:0] b_reg;
    logic signed [PROD_W-1:0] acc_reg;

    // Shift-add one multiplier bit per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start_i && !busy_reg) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == 4'd15) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start_i && !busy_reg) begin
            a_reg   <= a_i;
            b_reg   <= PROD_W'(b_i);
            acc_reg <= '0;
        end else if (busy_reg) begin
            if (a_reg[0])
                acc_reg <= acc_reg + b_reg;
            a_reg <= a_reg >> 1;
            b_reg <= b_reg <<< 1;
        end
    end

    assign done_o = done_reg;
    assign prod_o = acc_reg;

endmodule

[rtl/core/cpt_div.sv]
// Restoring divider, one quotient bit per cycle: 48-bit dividend by 16-bit divisor.
// Depends on cpt_pkg.
module cpt_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start_i,
    input  logic [cpt_pkg::PROD_W-1:0]  dividend_i,
    input  logic [cpt_pkg::DT_W-1:0]    divisor_i,
    output logic                        done_o,
    output logic [cpt_pkg::PROD_W-1:0]  quot_o
);
    import cpt_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [5:0]        cnt_reg;
    logic [DT_W-1:0]   d_reg;
    logic [DT_W-1:0]   rem_reg;
    logic [PROD_W-1:0] q_reg;
    logic [DT_W:0]     shifted;
    logic [DT_W+1:0]   trial;

    // Trial subtract of the shifted remainder
    always_comb begin
        shifted = {rem_reg, q_reg[PROD_W-1]};
        trial   = {1'b0, shifted} - {2'b00, d_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start_i && !busy_reg) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'(PROD_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start_i && !busy_reg) begin
            d_reg   <= divisor_i;
            rem_reg <= '0;
            q_reg   <= dividend_i;
        end else if (busy_reg) begin
            if (!trial[DT_W+1]) begin
                rem_reg <= trial[DT_W-1:0];
                q_reg   <= {q_reg[PROD_W-2:0], 1'b1};
            end else begin
                rem_reg <= shifted[DT_W-1:0];
                q_reg   <= {q_reg[PROD_W-2:0], 1'b0};
            end
        end
    end

    assign done_o = done_reg;
    assign quot_o = q_reg;

endmodule

[rtl/core/cascaded_pid_tracking_axis.sv]
// Cascaded position/velocity PID tracking controller, one axis sample per transfer.
// Sequence: a started axis with nonzero step time runs two integral products, two serial
// divides and six gain products; with zero step time the divides are skipped; an axis's
// first sample runs only the six gain products; an out-of-range axis goes straight to the
// output. One item at a time. Reset (aresetn low, synchronous) clears gains, started flags
// and handshake state; no clearing pass.
module cascaded_pid_tracking_axis #(
    parameter int NUM_AXES = 3
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // tdata: step_time[15:0], target_pos[47:16], target_vel[79:48], target_acc[111:80],
    //        meas_pos[143:112], meas_vel[175:144]
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [175:0]                       s_tdata,
    input  logic [1:0]                         s_tuser,   // axis[1:0]
    // tdata: vel_cmd[31:0], acc_cmd[63:32]
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [63:0]                        m_tdata,
    output logic [1:0]                         m_tuser,   // out_axis[1:0]
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [cpt_pkg::CIDX_W-1:0]         cfg_index,
    input  logic [cpt_pkg::CFG_W-1:0]          cfg_data
);
    import cpt_pkg::*;

    localparam int IW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

    cpt_state_t state_reg, state_next;
    logic [2:0] sel_reg, sel_next;

    logic [CFG_W-1:0] gain_reg [NUM_GAIN_REGS];

    logic [NUM_AXES-1:0]        started_reg;
    logic signed [DATA_W-1:0]   psum_mem  [NUM_AXES];
    logic signed [DATA_W-1:0]   vsum_mem  [NUM_AXES];
    logic signed [DATA_W-1:0]   lastp_mem [NUM_AXES];
    logic signed [DATA_W-1:0]   lastv_mem [NUM_AXES];

    logic [1:0]               axis_reg;
    logic [IW-1:0]            idx_reg;
    logic                     range_reg;
    logic                     first_reg;
    logic [DT_W-1:0]          dt_reg;
    logic signed [DATA_W-1:0] pe_reg, ve_reg, lastp_reg, lastv_reg;
    logic signed [DATA_W-1:0] psum_reg, vsum_reg, pd_reg, vd_reg;
    logic signed [ACC_W-1:0]  vacc_reg, aacc_reg;
    logic                     neg_reg;

    logic                     m_tvalid_reg;
    logic [63:0]              m_tdata_reg;
    logic [1:0]               m_tuser_reg;

    // Input field views
    logic [DT_W-1:0]          in_dt;
    logic signed [DATA_W-1:0] in_tp, in_tv, in_ta, in_mp, in_mv, in_pe, in_ve;
    logic [IW-1:0]            in_idx;
    logic                     in_range;
    logic                     accept;

    assign in_dt = s_tdata[15:0];
    assign in_tp = s_tdata[47:16];
    assign in_tv = s_tdata[79:48];
    assign in_ta = s_tdata[111:80];
    assign in_mp = s_tdata[143:112];
    assign in_mv = s_tdata[175:144];
    assign in_pe = sat32(64'(in_tp) - 64'(in_mp));
    assign in_ve = sat32(64'(in_tv) - 64'(in_mv));
    assign in_idx   = IW'(s_tuser);
    assign in_range = (int'(s_tuser) < NUM_AXES);

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Arithmetic unit hookup
    logic                     mul_start, mul_done;
    logic [GAIN_W-1:0]        mul_a;
    logic signed [DATA_W-1:0] mul_b;
    logic signed [PROD_W-1:0] mul_prod;
    logic                     div_start, div_done;
    logic [PROD_W-1:0]        div_quot;
    logic signed [DATA_W:0]   err_diff;
    logic                     diff_neg;
    logic [DATA_W-1:0]        diff_mag;
    logic [GAIN_W-1:0]        cur_gain;
    logic signed [DATA_W-1:0] cur_val;
    logic signed [DATA_W-1:0] int_new, div_res;

    assign mul_start = (state_reg == ST_INT_GO) || (state_reg == ST_MUL_GO);
    assign div_start = (state_reg == ST_DIV_GO);

    // Pick the gain and operand for the current product
    always_comb begin
        if (axis_reg < 2'(GAIN_AXES))
            cur_gain = gain_reg[sel_reg][GAIN_W*axis_reg +: GAIN_W];
        else
            cur_gain = '0;
        case (sel_reg)
            REG_POS_P: cur_val = pe_reg;
            REG_POS_I: cur_val = psum_reg;
            REG_POS_D: cur_val = pd_reg;
            REG_VEL_P: cur_val = ve_reg;
            REG_VEL_I: cur_val = vsum_reg;
            REG_VEL_D: cur_val = vd_reg;
            default:   cur_val = '0;
        endcase
    end

    always_comb begin
        if (state_reg == ST_INT_GO || state_reg == ST_INT_WAIT) begin
            mul_a = dt_reg;
            mul_b = (sel_reg == 3'd0) ? pe_reg : ve_reg;
        end else begin
            mul_a = cur_gain;
            mul_b = cur_val;
        end
    end

    // Error difference for the derivative, split into sign and magnitude
    always_comb begin
        if (sel_reg == 3'd0)
            err_diff = (DATA_W+1)'(pe_reg) - (DATA_W+1)'(lastp_reg);
        else
            err_diff = (DATA_W+1)'(ve_reg) - (DATA_W+1)'(lastv_reg);
        diff_neg = err_diff[DATA_W];
        diff_mag = diff_neg ? DATA_W'(-err_diff) : DATA_W'(err_diff);
    end

    // Integral update and signed, saturated quotient
    always_comb begin
        if (sel_reg == 3'd0)
            int_new = sat32(64'(psum_reg) + 64'(mul_prod >>> 16));
        else
            int_new = sat32(64'(vsum_reg) + 64'(mul_prod >>> 16));
        if (neg_reg)
            div_res = sat32(-signed'(64'(div_quot)));
        else
            div_res = sat32(signed'(64'(div_quot)));
    end

    cpt_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start_i (mul_start),
        .a_i     (mul_a),
        .b_i     (mul_b),
        .done_o  (mul_done),
        .prod_o  (mul_prod)
    );

    cpt_div u_div (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start_i    (div_start),
        .dividend_i ({diff_mag, 16'h0000}),
        .divisor_i  (dt_reg),
        .done_o     (div_done),
        .quot_o     (div_quot)
    );

    // Sequencer next state
    always_comb begin
        state_next = state_reg;
        sel_next   = sel_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    sel_next = '0;
                    if (!in_range)
                        state_next = ST_OUT;
                    else if (!started_reg[in_idx])
                        state_next = ST_MUL_GO;
                    else
                        state_next = ST_INT_GO;
                end
            end
            ST_INT_GO:  state_next = ST_INT_WAIT;
            ST_INT_WAIT: begin
                if (mul_done) begin
                    if (sel_reg == 3'd0) begin
                        sel_next   = 3'd1;
                        state_next = ST_INT_GO;
                    end else begin
                        sel_next   = 3'd0;
                        state_next = (dt_reg != '0) ? ST_DIV_GO : ST_MUL_GO;
                    end
                end
            end
            ST_DIV_GO:  state_next = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (div_done) begin
                    if (sel_reg == 3'd0) begin
                        sel_next   = 3'd1;
                        state_next = ST_DIV_GO;
                    end else begin
                        sel_next   = 3'd0;
                        state_next = ST_MUL_GO;
                    end
                end
            end
            ST_MUL_GO:  state_next = ST_MUL_WAIT;
            ST_MUL_WAIT: begin
                if (mul_done) begin
                    sel_next = sel_reg + 3'd1;
                    if (sel_reg == 3'(NUM_GAIN_REGS - 1))
                        state_next = ST_OUT;
                    else
                        state_next = ST_MUL_GO;
                end
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            sel_reg   <= '0;
        end else begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

    // Gain registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_GAIN_REGS; i++)
                gain_reg[i] <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_POS_P, REG_POS_I, REG_POS_D,
                REG_VEL_P, REG_VEL_I, REG_VEL_D: gain_reg[cfg_index] <= cfg_data;
                default: ;
            endcase
        end
    end

    // Per-axis started flags
    always_ff @(posedge aclk) begin
        if (!aresetn)
            started_reg <= '0;
        else if (accept && in_range)
            started_reg[in_idx] <= 1'b1;
    end

    // Per-axis error history and integrals
    always_ff @(posedge aclk) begin
        if (accept && in_range) begin
            lastp_mem[in_idx] <= in_pe;
            lastv_mem[in_idx] <= in_ve;
        end
        if (state_reg == ST_OUT && state_next == ST_IDLE && range_reg) begin
            psum_mem[idx_reg] <= psum_reg;
            vsum_mem[idx_reg] <= vsum_reg;
        end
    end

    // Working registers of the current item
    always_ff @(posedge aclk) begin
        if (accept) begin
            axis_reg  <= s_tuser;
            idx_reg   <= in_idx;
            range_reg <= in_range;
            first_reg <= !started_reg[in_idx];
            dt_reg    <= in_dt;
            pe_reg    <= in_pe;
            ve_reg    <= in_ve;
            lastp_reg <= lastp_mem[in_idx];
            lastv_reg <= lastv_mem[in_idx];
            pd_reg    <= '0;
            vd_reg    <= '0;
            if (in_range && started_reg[in_idx]) begin
                psum_reg <= psum_mem[in_idx];
                vsum_reg <= vsum_mem[in_idx];
            end else begin
                psum_reg <= '0;
                vsum_reg <= '0;
            end
            if (in_range) begin
                vacc_reg <= ACC_W'(in_tv) <<< 8;
                aacc_reg <= (ACC_W'(in_ta) <<< 8)
                            + ((s_tuser == GRAVITY_AXIS) ? GRAVITY_ACC : '0);
            end else begin
                vacc_reg <= '0;
                aacc_reg <= '0;
            end
        end
        if (state_reg == ST_INT_WAIT && mul_done) begin
            if (sel_reg == 3'd0)
                psum_reg <= int_new;
            else
                vsum_reg <= int_new;
        end
        if (state_reg == ST_DIV_GO)
            neg_reg <= diff_neg;
        if (state_reg == ST_DIV_WAIT && div_done) begin
            if (sel_reg == 3'd0)
                pd_reg <= div_res;
            else
                vd_reg <= div_res;
        end
        if (state_reg == ST_MUL_WAIT && mul_done) begin
            aacc_reg <= aacc_reg + ACC_W'(mul_prod);
            if (sel_reg < REG_VEL_P)
                vacc_reg <= vacc_reg + ACC_W'(mul_prod);
        end
    end

    // Output register: load on leaving the output state, drop on transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == ST_OUT && state_next == ST_IDLE) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_OUT && state_next == ST_IDLE) begin
            m_tuser_reg <= axis_reg;
            m_tdata_reg <= {sat32(64'(aacc_reg >>> 8)), sat32(64'(vacc_reg >>> 8))};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // A transfer in always starts the sequencer
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg != ST_IDLE)
        else $error("sequencer idle after input transfer");

    // Out-of-range axis yields zero commands
    a_range_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && !range_reg) |-> (vacc_reg == '0 && aacc_reg == '0))
        else $error("nonzero accumulator for out-of-range axis");

    // Multiplier completes only while the sequencer waits on it
    a_mul_done: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> (state_reg == ST_INT_WAIT || state_reg == ST_MUL_WAIT))
        else $error("multiplier done outside a wait state");

    // Divider runs only for a started axis with nonzero step time
    a_div_cond: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> (dt_reg != '0 && !first_reg))
        else $error("divide launched with zero step time or on first sample");

endmodule

[sim/cascaded_pid_tracking_axis_tb.sv]
// Self-checking bench for the cascaded PID tracking block: drives axis samples,
// predicts velocity and acceleration commands per axis and checks each result.
// Depends on cpt_pkg and cascaded_pid_tracking_axis.
`timescale 1ns / 1ps
module cascaded_pid_tracking_axis_tb;
    import cpt_pkg::*;

    localparam int AXES = 3;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 300;

    typedef struct packed {
        logic [1:0]  axis;
        logic [15:0] step_time;
        logic signed [31:0] target_pos, target_vel, target_acc, meas_pos, meas_vel;
    } sample_t;

    typedef struct packed {
        logic [1:0] axis;
        logic signed [31:0] vel_cmd, acc_cmd;
    } command_t;

    logic aclk = 1'b0, aresetn = 1'b0;
    logic s_tvalid = 1'b0, s_tready;
    logic [175:0] s_tdata = '0;
    logic [1:0] s_tuser = '0;
    logic m_tvalid, m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic [1:0] m_tuser;
    logic cfg_valid = 1'b0, cfg_ready;
    logic [CIDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    cascaded_pid_tracking_axis #(.NUM_AXES(AXES)) u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    sample_t  pending_samples[$];
    command_t expected_cmds[$];
    int errors = 0;
    int send_idle_pct = 0, recv_stall_pct = 0;
    bit hold_off = 1'b0;
    bit cfg_req = 1'b0;
    int quiet_cycles = 0;

    // predictor state
    logic [CFG_W-1:0] gain_reg[NUM_GAIN_REGS];
    logic signed [31:0] pos_sum[AXES], vel_sum[AXES], prev_pos_err[AXES], prev_vel_err[AXES];
    bit started[AXES];

    function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [63:0] floor_shr(input logic signed [63:0] x, input int s);
        return x >>> s;
    endfunction

    function automatic logic signed [63:0] gain(input int r, input int a);
        if (a >= GAIN_AXES) return 0;
        return $signed({48'd0, gain_reg[r][16*a +: 16]});
    endfunction

    // Work out the command pair for one sample and advance the axis state
    function automatic command_t predict_command(input sample_t s);
        command_t c;
        int a;
        logic signed [63:0] dt, pe, ve, pd, vd, pfb, vfb, vacc, aacc;
        a = s.axis;
        c.axis = s.axis;
        c.vel_cmd = 0;
        c.acc_cmd = 0;
        if (a >= AXES) return c;
        dt = $signed({48'd0, s.step_time});
        pe = clamp32(64'(s.target_pos) - 64'(s.meas_pos));
        ve = clamp32(64'(s.target_vel) - 64'(s.meas_vel));
        if (!started[a]) begin
            pos_sum[a] = 0;
            vel_sum[a] = 0;
            pd = 0;
            vd = 0;
            started[a] = 1'b1;
        end else begin
            pos_sum[a] = clamp32(64'(pos_sum[a]) + floor_shr(dt * pe, 16));
            vel_sum[a] = clamp32(64'(vel_sum[a]) + floor_shr(dt * ve, 16));
            if (dt != 0) begin
                pd = clamp32(((pe - 64'(prev_pos_err[a])) * 65536) / dt);
                vd = clamp32(((ve - 64'(prev_vel_err[a])) * 65536) / dt);
            end else begin
                pd = 0;
                vd = 0;
            end
        end
        prev_pos_err[a] = pe[31:0];
        prev_vel_err[a] = ve[31:0];
        pfb = gain(REG_POS_P, a) * pe + gain(REG_POS_I, a) * 64'(pos_sum[a])
            + gain(REG_POS_D, a) * pd;
        vfb = gain(REG_VEL_P, a) * ve + gain(REG_VEL_I, a) * 64'(vel_sum[a])
            + gain(REG_VEL_D, a) * vd;
        vacc = 64'(s.target_vel) * 256 + pfb;
        aacc = 64'(s.target_acc) * 256 + pfb + vfb;
        if (a == GRAVITY_AXIS) aacc += 64'sd642253 * 256;
        c.vel_cmd = clamp32(floor_shr(vacc, 8));
        c.acc_cmd = clamp32(floor_shr(aacc, 8));
        return c;
    endfunction

    task automatic report(input string what, input logic signed [31:0] got,
                          input logic signed [31:0] want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        errors++;
    endtask

    // Driver: offer queued samples, predict at acceptance; issue register writes
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                expected_cmds.push_back(predict_command(pending_samples.pop_front()));
            if (cfg_valid && cfg_ready) cfg_valid <= 1'b0;
            else if (cfg_req && !cfg_valid) cfg_valid <= 1'b1;
            if (!(s_tvalid && !s_tready)) begin
                if (pending_samples.size() != 0 &&
                    ($urandom_range(99) >= send_idle_pct)) begin
                    s_tvalid <= 1'b1;
                    s_tuser <= pending_samples[0].axis;
                    s_tdata <= {pending_samples[0].meas_vel, pending_samples[0].meas_pos,
                                pending_samples[0].target_acc, pending_samples[0].target_vel,
                                pending_samples[0].target_pos, pending_samples[0].step_time};
                end else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: stall at random and compare each transfer with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn) begin
            m_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (m_tvalid && m_tready) begin
                if (expected_cmds.size() == 0) begin
                    report("unexpected result axis", 32'(m_tuser), 0);
                end else begin
                    command_t w;
                    w = expected_cmds.pop_front();
                    if (m_tuser !== w.axis) report("axis", m_tuser, w.axis);
                    if (m_tdata[31:0] !== w.vel_cmd) report("vel_cmd", m_tdata[31:0], w.vel_cmd);
                    if (m_tdata[63:32] !== w.acc_cmd) report("acc_cmd", m_tdata[63:32], w.acc_cmd);
                end
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic write_gain(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_req = 1'b1;
        @(posedge aclk);
        while (!(cfg_valid && cfg_ready)) @(posedge aclk);
        cfg_req = 1'b0;
        if (idx < NUM_GAIN_REGS) gain_reg[idx] = val;
    endtask

    task automatic wait_drained();
        while (pending_samples.size() != 0 || expected_cmds.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic signed [31:0] rand_value(input int mode);
        case (mode)
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2: return $signed(32'($urandom_range(131072)) - 32'sd65536);
            default: return $signed($urandom);
        endcase
    endfunction

    function automatic sample_t rand_sample(input bit wild_axis);
        sample_t s;
        s.axis = wild_axis ? 2'($urandom_range(3)) : 2'($urandom_range(2));
        case ($urandom_range(9))
            0: s.step_time = 16'd0;
            1: s.step_time = 16'hFFFF;
            default: s.step_time = 16'($urandom);
        endcase
        s.target_pos = rand_value($urandom_range(9) < 7 ? 2 : $urandom_range(3));
        s.target_vel = rand_value($urandom_range(9) < 7 ? 2 : $urandom_range(3));
        s.target_acc = rand_value($urandom_range(9) < 7 ? 2 : $urandom_range(3));
        s.meas_pos = rand_value($urandom_range(9) < 7 ? 2 : $urandom_range(3));
        s.meas_vel = rand_value($urandom_range(9) < 7 ? 2 : $urandom_range(3));
        return s;
    endfunction

    function automatic logic [CFG_W-1:0] rand_gains(input int mode);
        case (mode)
            0: return '0;
            1: return '1;
            2: return {3{16'($urandom_range(1023))}};
            default: return {16'($urandom), 32'($urandom)};
        endcase
    endfunction

    initial begin
        sample_t s;
        int phase;
        for (int r = 0; r < NUM_GAIN_REGS; r++) gain_reg[r] = '0;
        for (int a = 0; a < AXES; a++) begin
            pos_sum[a] = 0; vel_sum[a] = 0; prev_pos_err[a] = 0; prev_vel_err[a] = 0;
            started[a] = 1'b0;
        end
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: 0x0100 gain per axis, writes to unused indices, first samples, extremes, bad axis
        for (int r = 0; r < NUM_GAIN_REGS; r++) write_gain(r, 48'h0100_0100_0100);
        write_gain(3'd6, '1);
        write_gain(3'd7, '1);
        for (int i = 0; i < 20; i++) begin
            s.axis = 2'(i % 4);
            s.step_time = (i < 8) ? 16'd1 : ((i < 12) ? 16'd0 : 16'hFFFF);
            s.target_pos = (i % 2) ? 32'sh7FFFFFFF : 32'sh80000000;
            s.meas_pos = (i % 2) ? 32'sh80000000 : 32'sh7FFFFFFF;
            s.target_vel = (i % 3 == 0) ? 32'sh7FFFFFFF : 32'sh00010000;
            s.meas_vel = (i % 3 == 1) ? 32'sh7FFFFFFF : 32'shFFFF0000;
            s.target_acc = (i % 2) ? 32'sh80000000 : 32'sh7FFFFFFF;
            pending_samples.push_back(s);
        end
        wait_drained();

        // random phases with varied gains and idling
        for (phase = 0; phase < 8; phase++) begin
            for (int r = 0; r < NUM_GAIN_REGS; r++) write_gain(r, rand_gains(phase % 4));
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
                default: begin send_idle_pct = 29; recv_stall_pct = 29; end
            endcase
            for (int i = 0; i < 200; i++)
                pending_samples.push_back(rand_sample($urandom_range(19) == 0));
            if (phase == 4) begin
                // long receiver hold-off while the sender keeps offering
                hold_off = 1'b1;
                repeat (1500) @(posedge aclk);
                hold_off = 1'b0;
            end
            wait_drained();
        end

        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

[sim.f]
rtl/core/cpt_pkg.sv
rtl/core/cpt_mul.sv
rtl/core/cpt_div.sv
rtl/core/cascaded_pid_tracking_axis.sv
sim/cascaded_pid_tracking_axis_tb.sv
